### rtl/mmmf_pkg.sv
// Package for the min/max/median finder: sizes, output beat layout and the
// sequencer state type. No dependencies.
`timescale 1ns / 1ps

package mmmf_pkg;

  localparam int MAX_ITEMS = 512;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 9;   // width of a load position (store address)
  localparam int CNT_W     = 10;  // width of a count, holds MAX_ITEMS itself
  localparam int RES_BITS  = 3 * VAL_W + 3 * POS_W + 1 + CNT_W + 1;
  localparam int RES_W     = ((RES_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_LOAD,   // taking sample beats
    ST_CAND,   // read address = candidate
    ST_CLAT,   // latch candidate, clear counts
    ST_SWEEP,  // stream every stored value past the comparator
    ST_DRAIN,  // last compare lands
    ST_EVAL,   // test counts against the border
    ST_PUT     // move result into the output register
  } mmmf_state_t;

endpackage

### rtl/min_max_median_finder_core.sv
// Top level of the min/max/median finder: value store, running min/max and
// the rank-count median sequencer. Depends on mmmf_pkg.
`timescale 1ns / 1ps

// Usage
//   Input: one signed 32-bit sample per beat on s_tdata; s_tlast marks the
//   last sample of a batch. A beat is taken at s_tvalid & s_tready. Up to
//   MAX_ITEMS samples are kept; later ones are dropped and flagged.
//   Output: one beat per batch on m_tdata after the last sample.
//   Throughput: one sample per cycle while loading. After the last beat the
//   median walk runs: each tried candidate takes a candidate read and its
//   latch, n reads streamed past one shared comparator, a drain and an
//   evaluation; once a candidate fits, ST_PUT loads the output register.
//   s_tready is low for the whole walk; the single-port store read sets its
//   length. Min and max are tracked during load, so they add no steps to it.
//   Stall: the result sits in an output register. A new batch loads while it
//   waits; a second result waits in ST_PUT until the first is taken.
//   Reset: rst (synchronous, active high) empties the batch and the output
//   register; the store itself is not cleared, only entries written in the
//   current batch are read.
module min_max_median_finder_core
  import mmmf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [31:0]      s_tdata,   // [31:0] sample_value
  input  logic             s_tlast,   // batch_end
  output logic             m_tvalid,
  input  logic             m_tready,
  // [31:0] minimum, [40:32] minimum_position, [72:41] maximum,
  // [81:73] maximum_position, [113:82] median, [122:114] median_position,
  // [123] median_exact, [133:124] batch_count, [134] overflowed, rest zero
  output logic [RES_W-1:0] m_tdata
);

  mmmf_state_t state, state_next;

  logic [VAL_W-1:0] mem [MAX_ITEMS];
  logic [VAL_W-1:0] rd_data;
  logic [POS_W-1:0] rd_addr;

  logic [CNT_W-1:0] kept;
  logic             ovf;
  logic signed [VAL_W-1:0] min_val, max_val;
  logic [POS_W-1:0] min_pos, max_pos;

  // batch snapshot for the walk
  logic [CNT_W-1:0] n, border;
  logic             b_ovf;

  logic [POS_W-1:0] i, j;
  logic signed [VAL_W-1:0] cand;
  logic [CNT_W-1:0] smaller, larger;
  logic             pend;

  logic signed [VAL_W-1:0] med_val;
  logic [POS_W-1:0] med_pos;
  logic             med_exact;

  logic in_beat, keep, lt, last_j, fits;

  assign s_tready = (state == ST_LOAD);
  assign in_beat  = s_tvalid & s_tready;
  assign keep     = in_beat && (kept < CNT_W'(MAX_ITEMS));
  assign last_j   = ({1'b0, j} == n - CNT_W'(1));
  assign fits     = (smaller <= border) && (larger <= border);

  // shared compare unit of the walk
  assign lt = $signed(rd_data) < cand;

  // store
  always_ff @(posedge clk) begin
    if (keep) begin
      mem[kept[POS_W-1:0]] <= s_tdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    rd_addr    = j;
    case (state)
      ST_LOAD:  if (in_beat && s_tlast) state_next = ST_CAND;
      ST_CAND: begin
        rd_addr    = i;
        state_next = ST_CLAT;
      end
      ST_CLAT:  state_next = ST_SWEEP;
      ST_SWEEP: if (last_j) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_EVAL;
      ST_EVAL:  state_next = fits ? ST_PUT : ST_CAND;
      ST_PUT:   if (!m_tvalid || m_tready) state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // load side: count, overflow, running min/max (first occurrence wins)
  always_ff @(posedge clk) begin
    if (rst) begin
      kept <= '0;
      ovf  <= 1'b0;
    end else if (state == ST_PUT && state_next == ST_LOAD) begin
      kept <= '0;
      ovf  <= 1'b0;
    end else if (keep) begin
      kept <= kept + CNT_W'(1);
    end else if (in_beat) begin
      ovf <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      if (kept == '0 || $signed(s_tdata) < min_val) begin
        min_val <= s_tdata;
        min_pos <= kept[POS_W-1:0];
      end
      if (kept == '0 || max_val < $signed(s_tdata)) begin
        max_val <= s_tdata;
        max_pos <= kept[POS_W-1:0];
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= (state == ST_SWEEP);
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && s_tlast) begin
      n      <= keep ? kept + CNT_W'(1) : kept;
      border <= (keep ? kept + CNT_W'(1) : kept) >> 1;
      b_ovf  <= ovf | ~keep;
      i      <= '0;
    end
    if (state == ST_CLAT) begin
      cand    <= rd_data;
      j       <= '0;
      smaller <= '0;
      larger  <= '0;
    end else begin
      if (state == ST_SWEEP) begin
        j <= j + POS_W'(1);
      end
      if (pend) begin
        if (lt) begin
          smaller <= smaller + CNT_W'(1);
        end else if ($signed(rd_data) != cand) begin
          larger <= larger + CNT_W'(1);
        end
      end
    end
    if (state == ST_EVAL) begin
      if (fits) begin
        med_pos   <= i;
        med_exact <= (smaller == border) || (larger == border);
        med_val   <= ((smaller == border) || (larger == border)) ? cand : '0;
      end else begin
        i <= i + POS_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_PUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PUT && (!m_tvalid || m_tready)) begin
      m_tdata <= RES_W'({b_ovf, n, med_exact, med_pos, med_val,
                         max_pos, max_val, min_pos, min_val});
    end
  end

  // checks
  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    kept <= CNT_W'(MAX_ITEMS))
    else $error("kept count above capacity");

  a_sweep_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SWEEP |-> {1'b0, j} < n)
    else $error("sweep address past batch");

  a_cand_exists: assert property (@(posedge clk) disable iff (rst)
    state == ST_CAND |-> {1'b0, i} < n)
    else $error("candidate walk ran past batch");

  a_counts_sane: assert property (@(posedge clk) disable iff (rst)
    state == ST_EVAL |-> smaller + larger < n)
    else $error("rank counts exceed batch size");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP || state == ST_EVAL) |-> !s_tready)
    else $error("input ready during median walk");

endmodule
